// ===== sv/lbo_pkg.sv =====
// Package for the lattice bond option block: types, codes, constants and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package lbo_pkg;

    localparam int MAX_LEVELS_DEF = 64;
    localparam int VAL_W          = 48;
    localparam int RATE_W         = 32;
    localparam int DT_W           = 32;
    localparam int CFG_IDX_W      = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // Input function codes
    localparam logic [1:0] FUNC_RATE  = 2'd0;
    localparam logic [1:0] FUNC_CPN   = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // Exercise modes
    localparam logic [1:0] MODE_EURO = 2'd0;
    localparam logic [1:0] MODE_BERM = 2'd1;
    localparam logic [1:0] MODE_AMER = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATURITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DT       = 3'd5;

    typedef struct packed {
        logic [1:0]       func;
        logic [5:0]       level;
        logic [5:0]       node;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] call_value;
        logic [VAL_W-1:0] put_value;
    } t_out;

    typedef struct packed {
        logic [VAL_W-1:0] c;
        logic [VAL_W-1:0] p;
    } t_pair;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [DT_W-1:0]   dt;
        logic [VAL_W-1:0]  c_avg;
        logic [VAL_W-1:0]  p_avg;
        logic [VAL_W-1:0]  coupon;
        logic [VAL_W-1:0]  strike;
        logic              ex;
    } t_node_req;

    typedef enum logic [3:0] {
        S_IDLE, S_CADD, S_INIT, S_FILL, S_LVL, S_LCPN,
        S_RRD, S_NODE, S_NWAIT, S_ROT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        N_IDLE, N_X, N_XW, N_TF, N_TD, N_TC, N_INT, N_EL, N_EW,
        N_CH, N_CL, N_PH, N_PL, N_FIN
    } t_nstate;

    function automatic logic [VAL_W-1:0] f_sat_add(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
    endfunction

    // Truncated exp(-f) series in Q32.32, evaluated at elaboration only.
    function automatic logic [63:0] f_series(input logic [63:0] f);
        logic signed [65:0] sum;
        logic [63:0]        term;
        sum  = 66'sh1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k <= 13; k++) begin
            term = (term * f) >> 32;
            term = term / 64'(k);
            if ((k & 1) != 0) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        return 64'(sum);
    endfunction

    function automatic logic [31:0] f_e1();
        logic [63:0] h;
        h = f_series(64'h8000_0000);
        return 32'((h * h) >> 32);
    endfunction

    localparam logic [31:0] EXP_E1 = f_e1();

    // floor(2^36 / k) for the series divisors from two upwards.
    function automatic logic [35:0] f_recip(input logic [3:0] k);
        logic [35:0] r;
        unique case (k)
            4'd2:    r = 36'd34359738368;
            4'd3:    r = 36'd22906492245;
            4'd4:    r = 36'd17179869184;
            4'd5:    r = 36'd13743895347;
            4'd6:    r = 36'd11453246122;
            4'd7:    r = 36'd9817068105;
            4'd8:    r = 36'd8589934592;
            4'd9:    r = 36'd7635497415;
            4'd10:   r = 36'd6871947673;
            4'd11:   r = 36'd6247225157;
            4'd12:   r = 36'd5726623061;
            4'd13:   r = 36'd5286113595;
            default: r = 36'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lbo_cell.sv =====
// One cell of the value row: holds a callable and a putable node value and shifts towards the head.
`timescale 1ns / 1ps
`default_nettype none
module lbo_cell (
    input  wire logic          i_clk,
    input  wire logic          i_load,
    input  wire logic          i_shift,
    input  wire lbo_pkg::t_pair i_load_val,
    input  wire lbo_pkg::t_pair i_next,
    output lbo_pkg::t_pair      o_val
);

    lbo_pkg::t_pair r_val;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_load_val;
        end else if (i_shift) begin
            r_val <= i_next;
        end
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

// ===== sv/lbo_node.sv =====
// Node unit: discount factor by series and repeated multiply, scaling, coupon and exercise clamp.
`timescale 1ns / 1ps
`default_nettype none
module lbo_node (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire lbo_pkg::t_node_req i_req,
    output logic                   o_done,
    output lbo_pkg::t_pair          o_res
);

    lbo_pkg::t_nstate   r_state, n_state;
    lbo_pkg::t_node_req r_req;
    lbo_pkg::t_pair     r_res;
    logic               r_done;
    logic [68:0]        r_prod;
    logic [32:0]        mul_a;
    logic [35:0]        mul_b;
    logic [9:0]         r_p;
    logic [31:0]        r_f;
    logic [32:0]        r_term;
    logic signed [34:0] r_sum;
    logic [3:0]         r_k;
    logic [32:0]        r_r;
    logic [63:0]        r_a;
    logic [47:0]        r_cs;

    logic [31:0]        w_t;
    logic [31:0]        w_q0;
    logic [35:0]        w_rem;
    logic [31:0]        w_q;
    logic [47:0]        w_cs;
    logic [47:0]        w_ps;
    logic [47:0]        w_c;
    logic [47:0]        w_p;

    function automatic logic [47:0] f_scale(input logic [63:0] a, input logic [47:0] b);
        logic [64:0] s;
        s = 65'(a >> 16) + ((65'({a[15:0], 16'h0000}) + 65'(b)) >> 32);
        return s[47:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbo_pkg::N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            lbo_pkg::N_IDLE: begin
                if (i_start) n_state = lbo_pkg::N_X;
            end
            lbo_pkg::N_X: begin
                mul_a   = {1'b0, r_req.rate};
                mul_b   = {4'h0, r_req.dt};
                n_state = lbo_pkg::N_XW;
            end
            lbo_pkg::N_XW: n_state = lbo_pkg::N_TF;
            lbo_pkg::N_TF: begin
                mul_a   = r_term;
                mul_b   = {4'h0, r_f};
                n_state = lbo_pkg::N_TD;
            end
            lbo_pkg::N_TD: begin
                if (r_k == 4'd1) begin
                    n_state = lbo_pkg::N_TF;
                end else begin
                    mul_a   = {1'b0, w_t};
                    mul_b   = lbo_pkg::f_recip(r_k);
                    n_state = lbo_pkg::N_TC;
                end
            end
            lbo_pkg::N_TC: n_state = (r_k == 4'd13) ? lbo_pkg::N_INT : lbo_pkg::N_TF;
            lbo_pkg::N_INT: n_state = lbo_pkg::N_EL;
            lbo_pkg::N_EL: begin
                if (r_p != '0 && r_r != '0) begin
                    mul_a   = r_r;
                    mul_b   = {4'h0, lbo_pkg::EXP_E1};
                    n_state = lbo_pkg::N_EW;
                end else begin
                    n_state = lbo_pkg::N_CH;
                end
            end
            lbo_pkg::N_EW: n_state = lbo_pkg::N_EL;
            lbo_pkg::N_CH: begin
                mul_a   = {1'b0, r_req.c_avg[47:16]};
                mul_b   = {4'h0, r_r[31:0]};
                n_state = lbo_pkg::N_CL;
            end
            lbo_pkg::N_CL: begin
                mul_a   = {17'h0, r_req.c_avg[15:0]};
                mul_b   = {4'h0, r_r[31:0]};
                n_state = lbo_pkg::N_PH;
            end
            lbo_pkg::N_PH: begin
                mul_a   = {1'b0, r_req.p_avg[47:16]};
                mul_b   = {4'h0, r_r[31:0]};
                n_state = lbo_pkg::N_PL;
            end
            lbo_pkg::N_PL: begin
                mul_a   = {17'h0, r_req.p_avg[15:0]};
                mul_b   = {4'h0, r_r[31:0]};
                n_state = lbo_pkg::N_FIN;
            end
            lbo_pkg::N_FIN: n_state = lbo_pkg::N_IDLE;
            default: n_state = lbo_pkg::N_IDLE;
        endcase
    end

    // Division of a series term by k: reciprocal estimate, then at most one correction.
    assign w_t   = r_prod[63:32];
    assign w_q0  = r_prod[67:36];
    assign w_rem = {4'h0, r_term[31:0]} - (36'(w_q0) * 36'(r_k));
    assign w_q   = (w_rem >= 36'(r_k)) ? w_q0 + 32'd1 : w_q0;

    // A factor of one or more leaves the value as it is.
    assign w_cs = r_r[32] ? r_req.c_avg : r_cs;
    assign w_ps = r_r[32] ? r_req.p_avg : f_scale(r_a, r_prod[47:0]);

    always_comb begin
        w_c = lbo_pkg::f_sat_add(w_cs, r_req.coupon);
        w_p = lbo_pkg::f_sat_add(w_ps, r_req.coupon);
        if (r_req.ex) begin
            if (w_c > r_req.strike) w_c = r_req.strike;
            if (w_p < r_req.strike) w_p = r_req.strike;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == lbo_pkg::N_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 69'(mul_a) * 69'(mul_b);
        unique case (r_state)
            lbo_pkg::N_IDLE: begin
                if (i_start) r_req <= i_req;
            end
            lbo_pkg::N_XW: begin
                r_p    <= r_prod[63:54];
                r_f    <= r_prod[53:22];
                r_term <= 33'h1_0000_0000;
                r_sum  <= 35'sh1_0000_0000;
                r_k    <= 4'd1;
            end
            lbo_pkg::N_TD: begin
                r_term <= {1'b0, w_t};
                if (r_k == 4'd1) begin
                    r_sum <= r_sum - $signed({3'b000, w_t});
                    r_k   <= 4'd2;
                end
            end
            lbo_pkg::N_TC: begin
                r_term <= {1'b0, w_q};
                if (r_k[0]) begin
                    r_sum <= r_sum - $signed({3'b000, w_q});
                end else begin
                    r_sum <= r_sum + $signed({3'b000, w_q});
                end
                r_k <= r_k + 4'd1;
            end
            lbo_pkg::N_INT: r_r <= r_sum[34] ? 33'h0 : r_sum[32:0];
            lbo_pkg::N_EW: begin
                r_r <= {1'b0, r_prod[63:32]};
                r_p <= r_p - 10'd1;
            end
            lbo_pkg::N_CL: r_a <= r_prod[63:0];
            lbo_pkg::N_PH: r_cs <= f_scale(r_a, r_prod[47:0]);
            lbo_pkg::N_PL: r_a <= r_prod[63:0];
            lbo_pkg::N_FIN: begin
                r_res.c <= w_c;
                r_res.p <= w_p;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ===== sv/lattice_bond_option_backward_induction.sv =====
// Top level: loads lattice rates and coupons, then values callable and putable bonds at the root.
//
// Input items arrive on i_in_valid / i_in_data and transfer when o_in_stall is low.
// A rate load is written as it transfers; a coupon add reads the store, adds and writes
// back, stalling the input meanwhile. A start item walks the lattice from the maturity
// level back to the root through a row of MAX_LEVELS cells. Each node is processed by
// one shared node unit whose work grows with P, the integer part of rate*dt (one multiply
// per unit of P in the exponent loop plus the series of thirteen terms). After the nodes
// of a level the row rotates back into place.
// The result appears on o_out_valid / o_out_data and transfers when i_out_stall is low;
// it is held in an output register, so rate and coupon loads may transfer while it waits.
// A finished valuation waits for that register to empty, then clears all coupons.
// Configuration writes use i_cfg_valid / o_cfg_ready (always ready); the user must make them
// while idle, the block does not enforce it. Reset is synchronous, active low: it restores
// the register defaults and empties the coupon store; rates are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module lattice_bond_option_backward_induction #(
    parameter int MAX_LEVELS = lbo_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire lbo_pkg::t_in                    i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output lbo_pkg::t_out                        o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lbo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lbo_pkg::VAL_W-1:0]       i_cfg_data
);

    localparam int LW = $clog2(MAX_LEVELS);
    localparam int RD = MAX_LEVELS * (MAX_LEVELS + 1) / 2;
    localparam int AW = $clog2(RD);
    localparam int PW = 2 * LW + 2;

    lbo_pkg::t_state    r_state, n_state;

    logic [1:0]         r_mode;
    logic [5:0]         r_expiry;
    logic [5:0]         r_mat;
    logic [47:0]        r_strike;
    logic [47:0]        r_face;
    logic [31:0]        r_dt;

    logic [31:0]        r_rate_mem [RD];
    logic [31:0]        r_rate_q;
    logic [47:0]        r_cpn_mem [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] r_cpn_vld;
    logic [47:0]        r_cpn_q;
    logic               r_cpn_q_vld;
    logic [LW-1:0]      cpn_raddr;
    logic [47:0]        w_cpn;

    logic [LW-1:0]      r_lvl;
    logic [47:0]        r_value;
    logic [LW-1:0]      r_i;
    logic [LW-1:0]      r_j;
    logic [LW-1:0]      r_cnt;
    logic [AW-1:0]      r_base;
    logic [47:0]        r_cpn;
    logic               r_ex;

    logic               r_out_vld;
    lbo_pkg::t_out      r_out;

    logic               w_accept;
    logic               w_rate_we;
    logic               w_cpn_ok;
    logic [AW-1:0]      w_waddr;
    logic [13:0]        w_tri_in;
    logic [LW-1:0]      w_mat;
    logic [PW-1:0]      w_tri_mat;
    logic               w_ex;
    logic               w_out_free;

    logic               c_load;
    logic               c_shift;
    logic               c_start;
    logic               c_tail_node;

    lbo_pkg::t_pair     w_val [MAX_LEVELS];
    lbo_pkg::t_pair     w_fill;
    lbo_pkg::t_pair     w_tail;
    lbo_pkg::t_node_req w_req;
    lbo_pkg::t_pair     w_res;
    logic               w_done;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_vld || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= lbo_pkg::MODE_AMER;
            r_expiry <= 6'd0;
            r_mat    <= 6'd63;
            r_strike <= '0;
            r_face   <= '0;
            r_dt     <= 32'd16777216;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lbo_pkg::CFG_MODE:     r_mode   <= i_cfg_data[1:0];
                lbo_pkg::CFG_EXPIRY:   r_expiry <= i_cfg_data[5:0];
                lbo_pkg::CFG_MATURITY: r_mat    <= i_cfg_data[5:0];
                lbo_pkg::CFG_STRIKE:   r_strike <= i_cfg_data;
                lbo_pkg::CFG_FACE:     r_face   <= i_cfg_data;
                lbo_pkg::CFG_DT:       r_dt     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Address arithmetic: entry of node j on level i is i*(i+1)/2 + j.
    assign w_tri_in  = 14'((14'(i_in_data.level) * (14'(i_in_data.level) + 14'd1)) >> 1);
    assign w_waddr   = AW'(w_tri_in + 14'(i_in_data.node));
    assign w_cpn_ok  = 9'(i_in_data.level) < 9'(MAX_LEVELS);
    assign w_rate_we = w_accept && (i_in_data.func == lbo_pkg::FUNC_RATE) && w_cpn_ok
                       && (i_in_data.node <= i_in_data.level);
    assign w_mat     = (9'(r_mat) >= 9'(MAX_LEVELS)) ? LW'(MAX_LEVELS - 1) : LW'(r_mat);
    assign w_tri_mat = PW'((PW'(w_mat) * (PW'(w_mat) + PW'(1))) >> 1);
    assign w_ex      = (9'(r_i) <= 9'(r_expiry))
                       && ((r_mode == lbo_pkg::MODE_AMER)
                           || ((r_mode == lbo_pkg::MODE_EURO) && (9'(r_i) == 9'(r_expiry))));

    // Rate store
    always_ff @(posedge i_clk) begin
        if (w_rate_we) begin
            r_rate_mem[w_waddr] <= i_in_data.value[31:0];
        end
        r_rate_q <= r_rate_mem[AW'(r_base + AW'(r_j))];
    end

    // Coupon store; an entry without its valid bit reads as zero.
    always_ff @(posedge i_clk) begin
        if (r_state == lbo_pkg::S_CADD) begin
            r_cpn_mem[r_lvl] <= lbo_pkg::f_sat_add(w_cpn, r_value);
        end
        r_cpn_q <= r_cpn_mem[cpn_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpn_vld   <= '0;
            r_cpn_q_vld <= 1'b0;
        end else begin
            r_cpn_q_vld <= r_cpn_vld[cpn_raddr] && !((r_state == lbo_pkg::S_CADD)
                                                     && (r_lvl == cpn_raddr));
            if (r_state == lbo_pkg::S_CADD) begin
                r_cpn_vld[r_lvl] <= 1'b1;
            end else if ((r_state == lbo_pkg::S_DONE) && w_out_free) begin
                r_cpn_vld <= '0;
            end
        end
    end

    assign w_cpn = r_cpn_q_vld ? r_cpn_q : '0;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        c_load      = 1'b0;
        c_shift     = 1'b0;
        c_start     = 1'b0;
        c_tail_node = 1'b0;
        cpn_raddr   = r_i;
        unique case (r_state)
            lbo_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                cpn_raddr  = LW'(i_in_data.level);
                if (w_accept) begin
                    if ((i_in_data.func == lbo_pkg::FUNC_CPN) && w_cpn_ok) begin
                        n_state = lbo_pkg::S_CADD;
                    end else if (i_in_data.func == lbo_pkg::FUNC_START) begin
                        n_state = lbo_pkg::S_INIT;
                    end
                end
            end
            lbo_pkg::S_CADD: n_state = lbo_pkg::S_IDLE;
            lbo_pkg::S_INIT: begin
                cpn_raddr = w_mat;
                n_state   = lbo_pkg::S_FILL;
            end
            lbo_pkg::S_FILL: begin
                c_load  = 1'b1;
                n_state = (r_i == '0) ? lbo_pkg::S_DONE : lbo_pkg::S_LVL;
            end
            lbo_pkg::S_LVL:  n_state = lbo_pkg::S_LCPN;
            lbo_pkg::S_LCPN: n_state = lbo_pkg::S_RRD;
            lbo_pkg::S_RRD:  n_state = lbo_pkg::S_NODE;
            lbo_pkg::S_NODE: begin
                c_start = 1'b1;
                n_state = lbo_pkg::S_NWAIT;
            end
            lbo_pkg::S_NWAIT: begin
                if (w_done) begin
                    c_shift     = 1'b1;
                    c_tail_node = 1'b1;
                    n_state     = (r_j == r_i) ? lbo_pkg::S_ROT : lbo_pkg::S_RRD;
                end
            end
            lbo_pkg::S_ROT: begin
                c_shift = 1'b1;
                if (r_cnt == LW'(MAX_LEVELS - 1)) begin
                    n_state = (r_i == '0) ? lbo_pkg::S_DONE : lbo_pkg::S_LVL;
                end
            end
            lbo_pkg::S_DONE: begin
                if (w_out_free) n_state = lbo_pkg::S_IDLE;
            end
            default: n_state = lbo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lbo_pkg::S_IDLE: begin
                r_lvl   <= LW'(i_in_data.level);
                r_value <= i_in_data.value;
            end
            lbo_pkg::S_INIT: begin
                r_i    <= w_mat;
                r_base <= AW'(w_tri_mat);
            end
            lbo_pkg::S_FILL: begin
                if (r_i != '0) begin
                    r_i    <= r_i - LW'(1);
                    r_base <= r_base - AW'(r_i);
                end
            end
            lbo_pkg::S_LVL: begin
                r_ex  <= w_ex;
                r_j   <= '0;
                r_cnt <= '0;
            end
            lbo_pkg::S_LCPN: r_cpn <= w_cpn;
            lbo_pkg::S_NWAIT: begin
                if (w_done) begin
                    r_cnt <= r_cnt + LW'(1);
                    if (r_j != r_i) r_j <= r_j + LW'(1);
                end
            end
            lbo_pkg::S_ROT: begin
                r_cnt <= r_cnt + LW'(1);
                if ((r_cnt == LW'(MAX_LEVELS - 1)) && (r_i != '0)) begin
                    r_i    <= r_i - LW'(1);
                    r_base <= r_base - AW'(r_i);
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == lbo_pkg::S_DONE) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lbo_pkg::S_DONE) && w_out_free) begin
            r_out.call_value <= w_val[0].c;
            r_out.put_value  <= w_val[0].p;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Row of cells; the head pair feeds the node unit and the tail takes the result,
    // or the head value again while the row rotates back into place.
    assign w_fill.c = lbo_pkg::f_sat_add(r_face, w_cpn);
    assign w_fill.p = lbo_pkg::f_sat_add(r_face, w_cpn);
    assign w_tail   = c_tail_node ? w_res : w_val[0];

    genvar g;
    generate
        for (g = 0; g < MAX_LEVELS; g++) begin : g_cell
            if (g < MAX_LEVELS - 1) begin : g_mid
                lbo_cell u_cell (
                    .i_clk      (i_clk),
                    .i_load     (c_load),
                    .i_shift    (c_shift),
                    .i_load_val (w_fill),
                    .i_next     (w_val[g+1]),
                    .o_val      (w_val[g])
                );
            end else begin : g_last
                lbo_cell u_cell (
                    .i_clk      (i_clk),
                    .i_load     (c_load),
                    .i_shift    (c_shift),
                    .i_load_val (w_fill),
                    .i_next     (w_tail),
                    .o_val      (w_val[g])
                );
            end
        end
    endgenerate

    assign w_req.rate   = r_rate_q;
    assign w_req.dt     = r_dt;
    assign w_req.c_avg  = 48'((49'(w_val[0].c) + 49'(w_val[1].c)) >> 1);
    assign w_req.p_avg  = 48'((49'(w_val[0].p) + 49'(w_val[1].p)) >> 1);
    assign w_req.coupon = r_cpn;
    assign w_req.strike = r_strike;
    assign w_req.ex     = r_ex;

    lbo_node u_node (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_res   (w_res)
    );

endmodule
`default_nettype wire
